[hdl/gfpd_pkg.sv]
// Package for the goal frame polar decoder: field widths, the frame size,
// the CORDIC angle table and the fixed-point constants of the bearing unit.
// No dependencies; used by the channel interfaces and the top level.
package gfpd_pkg;

  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ANGLE_W     = 12;
  localparam int unsigned DIST_W      = 12;
  localparam int unsigned RWALL_W     = 9;
  localparam int unsigned LWALL_W     = 8;

  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'd2;
  localparam logic [BYTE_W-1:0] MISSING_BYTE = 8'd255;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 12;
  localparam int unsigned VEC_SHIFT    = 20;

  // Angle accumulator offsets: (base + full turn) * 2^16 + half an LSB.
  localparam logic signed [31:0] ZOFS_FRONT = 32'sd235962368;  // 3600*65536 + 32768
  localparam logic signed [31:0] ZOFS_BACK  = 32'sd353927168;  // 5400*65536 + 32768
  localparam logic [12:0]        FULL_TURN  = 13'd3600;
  localparam logic [ANGLE_W-1:0] CENTER_ANGLE = 12'd900;

  typedef logic [BYTE_W-1:0] byte_t;

  // atan(2^-i) in tenths of a degree, times 2^16.
  function automatic logic [24:0] atan_step(input logic [3:0] i);
    logic [24:0] a;
    case (i)
      4'd0:    a = 25'd29491200;
      4'd1:    a = 25'd17409672;
      4'd2:    a = 25'd9198793;
      4'd3:    a = 25'd4669451;
      4'd4:    a = 25'd2343786;
      4'd5:    a = 25'd1173036;
      4'd6:    a = 25'd586661;
      4'd7:    a = 25'd293348;
      4'd8:    a = 25'd146676;
      4'd9:    a = 25'd73339;
      4'd10:   a = 25'd36669;
      4'd11:   a = 25'd18335;
      4'd12:   a = 25'd9167;
      4'd13:   a = 25'd4584;
      4'd14:   a = 25'd2292;
      4'd15:   a = 25'd1146;
      default: a = 25'd0;
    endcase
    return a;
  endfunction

endpackage

[hdl/gfpd_in_if.sv]
// Input channel of the goal frame polar decoder: one raw 7-byte block per word.
// Depends on gfpd_pkg for the byte width.
interface gfpd_in_if;
  logic valid;
  logic ready;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_0;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_1;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_2;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_3;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_4;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_5;
  logic [gfpd_pkg::BYTE_W-1:0] raw_byte_6;

  modport source (output valid, raw_byte_0, raw_byte_1, raw_byte_2, raw_byte_3,
                  raw_byte_4, raw_byte_5, raw_byte_6, input ready);
  modport sink   (input valid, raw_byte_0, raw_byte_1, raw_byte_2, raw_byte_3,
                  raw_byte_4, raw_byte_5, raw_byte_6, output ready);
endinterface

[hdl/gfpd_out_if.sv]
// Result channel of the goal frame polar decoder: goal bearings, distances and
// wall offsets, one word per decoded block. Depends on gfpd_pkg for widths.
interface gfpd_out_if;
  logic valid;
  logic ready;
  logic                                      header_found;
  logic                                      own_goal_found;
  logic [gfpd_pkg::ANGLE_W-1:0]              own_goal_angle;
  logic [gfpd_pkg::DIST_W-1:0]               own_goal_distance;
  logic                                      opp_goal_found;
  logic [gfpd_pkg::ANGLE_W-1:0]              opp_goal_angle;
  logic [gfpd_pkg::DIST_W-1:0]               opp_goal_distance;
  logic                                      right_wall_found;
  logic signed [gfpd_pkg::RWALL_W-1:0]       right_wall_offset;
  logic                                      left_wall_found;
  logic signed [gfpd_pkg::LWALL_W-1:0]       left_wall_offset;

  modport source (output valid, header_found, own_goal_found, own_goal_angle,
                  own_goal_distance, opp_goal_found, opp_goal_angle, opp_goal_distance,
                  right_wall_found, right_wall_offset, left_wall_found, left_wall_offset,
                  input ready);
  modport sink   (input valid, header_found, own_goal_found, own_goal_angle,
                  own_goal_distance, opp_goal_found, opp_goal_angle, opp_goal_distance,
                  right_wall_found, right_wall_offset, left_wall_found, left_wall_offset,
                  output ready);
endinterface

[hdl/gfpd_cfg_if.sv]
// Configuration write channel of the goal frame polar decoder: one bit that
// tells which goal in the frame is ours. No dependencies.
interface gfpd_cfg_if;
  logic valid;
  logic ready;
  logic yellow_is_mine;

  modport source (output valid, yellow_is_mine, input ready);
  modport sink   (input valid, yellow_is_mine, output ready);
endinterface

[hdl/goal_frame_polar_decoder.sv]
// Goal frame polar decoder top level: header alignment, shared CORDIC and
// square-root sequencer, output register. Depends on gfpd_pkg and the
// gfpd_in_if, gfpd_out_if and gfpd_cfg_if channel interfaces.
//
//   channel   dir  word                                   handshake
//   in_ch     in   raw_byte_0..raw_byte_6 (7 x 8 bits)    valid/ready
//   out_ch    out  goal found/angle/distance, walls       valid/ready
//   cfg       in   yellow_is_mine (1 bit)                 valid/ready, ready always high
//
// The edge that accepts a block also latches and aligns it. The two goals then
// are worked in turn, each through operand setup, squaring of dx and dy on a
// shared 9x9 multiplier, 16 CORDIC rotations with a square-root digit running
// beside the first 12, and a step that finishes the bearing; the output
// register is then loaded. A new block is taken only after that load.
// in_ch is not ready while a block is being worked; a full output register
// stalls only the load cycle.
// Reset (rst, synchronous) clears the stored frame to zeros, the polarity bit and the output valid flag.
module goal_frame_polar_decoder (
  input  logic       clk,
  input  logic       rst,
  gfpd_in_if.sink    in_ch,
  gfpd_out_if.source out_ch,
  gfpd_cfg_if.sink   cfg
);
  import gfpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SQ_X,
    S_SQ_Y,
    S_ITER,
    S_FINISH,
    S_PUBLISH
  } state_t;

  state_t state;

  // Aligned frame, kept across blocks that carry no header.
  byte_t frame [FRAME_BYTES];
  logic  yellow_is_mine;
  logic  hdr_seen;

  // Goal sequencing: goal_sel 0 is our goal, 1 the opponent's.
  logic       goal_sel;
  logic [3:0] cnt;

  // Per-goal working registers.
  logic              g_found;
  logic              g_center;
  logic              g_back;
  logic signed [8:0] dx;
  logic signed [8:0] dy;
  logic [15:0]       sumsq;
  logic signed [31:0] u;
  logic signed [31:0] v;
  logic signed [31:0] z;
  logic [23:0]       nsh;
  logic [13:0]       rem;
  logic [11:0]       root;

  // Staged results for the own goal while the opponent goal is worked.
  logic                own_found;
  logic [ANGLE_W-1:0]  own_angle;
  logic [DIST_W-1:0]   own_dist;
  logic                opp_found;
  logic [ANGLE_W-1:0]  opp_angle;
  logic [DIST_W-1:0]   opp_dist;

  // Output register.
  logic                     o_valid;
  logic                     o_header_found;
  logic                     o_own_found;
  logic [ANGLE_W-1:0]       o_own_angle;
  logic [DIST_W-1:0]        o_own_dist;
  logic                     o_opp_found;
  logic [ANGLE_W-1:0]       o_opp_angle;
  logic [DIST_W-1:0]        o_opp_dist;
  logic                     o_rwall_found;
  logic signed [RWALL_W-1:0] o_rwall;
  logic                     o_lwall_found;
  logic signed [LWALL_W-1:0] o_lwall;

  // ---------------------------------------------------------------------
  // Header search and rotation of the incoming block. The last header byte
  // wins, so the scan runs upward and keeps overwriting the index.
  // ---------------------------------------------------------------------
  byte_t      raw [FRAME_BYTES];
  byte_t      rotated [FRAME_BYTES];
  logic [2:0] hdr_idx;
  logic       hdr_hit;

  assign raw[0] = in_ch.raw_byte_0;
  assign raw[1] = in_ch.raw_byte_1;
  assign raw[2] = in_ch.raw_byte_2;
  assign raw[3] = in_ch.raw_byte_3;
  assign raw[4] = in_ch.raw_byte_4;
  assign raw[5] = in_ch.raw_byte_5;
  assign raw[6] = in_ch.raw_byte_6;

  always_comb begin
    logic [3:0] src;
    hdr_idx = '0;
    hdr_hit = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (raw[i] == HEADER_BYTE) begin
        hdr_idx = 3'(i);
        hdr_hit = 1'b1;
      end
    end
    for (int i = 0; i < FRAME_BYTES; i++) begin
      src = 4'({1'b0, hdr_idx}) + 4'(i);
      if (src >= 4'(FRAME_BYTES)) begin
        src = src - 4'(FRAME_BYTES);
      end
      rotated[i] = raw[src[2:0]];
    end
  end

  // ---------------------------------------------------------------------
  // Operand selection for the goal being worked. With the register set,
  // frame bytes 1 and 2 are our goal; otherwise bytes 3 and 4 are.
  // ---------------------------------------------------------------------
  byte_t xb;
  byte_t yb;

  always_comb begin
    if (goal_sel ^ yellow_is_mine) begin
      xb = frame[1];
      yb = frame[2];
    end else begin
      xb = frame[3];
      yb = frame[4];
    end
  end

  // Shared squaring multiplier: dx in S_SQ_X, then dy in S_SQ_Y.
  logic signed [8:0]  mul_op;
  logic signed [17:0] mul_prod;

  assign mul_op   = (state == S_SQ_X) ? dx : dy;
  assign mul_prod = mul_op * mul_op;

  // One CORDIC rotation per cycle; the shift amount is the step count.
  logic signed [31:0] su;
  logic signed [31:0] sv;
  logic signed [31:0] atan_ext;

  assign su       = u >>> cnt;
  assign sv       = v >>> cnt;
  assign atan_ext = 32'($signed({1'b0, atan_step(cnt)}));

  // One restoring square-root digit per cycle; the next two radicand bits
  // come off the top of a shifting copy of the radicand.
  logic [15:0] sq_rem_in;
  logic [15:0] sq_trial;
  logic        sq_fit;

  assign sq_rem_in = {rem, nsh[23:22]};
  assign sq_trial  = {2'b00, root, 2'b01};
  assign sq_fit    = sq_rem_in >= sq_trial;

  // Final bearing: add base and full turn, round, wrap once into 0..3599.
  logic signed [31:0] z_fin;
  logic [12:0]        ang_raw;
  logic [12:0]        ang_wrap;
  logic [ANGLE_W-1:0] angle_res;
  logic [DIST_W-1:0]  dist_res;

  always_comb begin
    z_fin    = z + (g_back ? ZOFS_BACK : ZOFS_FRONT);
    ang_raw  = z_fin[28:16];
    ang_wrap = (ang_raw >= FULL_TURN) ? ang_raw - FULL_TURN : ang_raw;
    if (!g_found) begin
      angle_res = '0;
    end else if (g_center) begin
      angle_res = CENTER_ANGLE;
    end else begin
      angle_res = ang_wrap[ANGLE_W-1:0];
    end
    // Round to nearest: the root goes up when the remainder exceeds it.
    if (!g_found) begin
      dist_res = '0;
    end else if ({2'b00, rem} > {4'd0, root}) begin
      dist_res = root + 12'd1;
    end else begin
      dist_res = root;
    end
  end

  // Wall fields come straight from the aligned frame.
  logic                      rwall_found;
  logic                      lwall_found;
  logic signed [RWALL_W-1:0] rwall_val;
  logic signed [LWALL_W-1:0] lwall_val;

  always_comb begin
    rwall_found = frame[5] != MISSING_BYTE;
    lwall_found = frame[6] != MISSING_BYTE;
    rwall_val   = rwall_found ? $signed(9'd128 - {1'b0, frame[5]}) : '0;
    lwall_val   = lwall_found ? $signed({~frame[6][7], frame[6][6:0]}) : '0;
  end

  logic signed [31:0] dx_ext;
  logic signed [31:0] dy_ext;

  assign dx_ext = 32'(dx);
  assign dy_ext = 32'(dy);

  // The output register takes a new word when it is empty or being drained.
  logic load_out;

  assign load_out = (state == S_PUBLISH) && (!o_valid || out_ch.ready);

  // ---------------------------------------------------------------------
  // Sequencer with its datapath and the output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      yellow_is_mine <= 1'b0;
      o_valid        <= 1'b0;
      goal_sel       <= 1'b0;
      cnt            <= '0;
      hdr_seen       <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        yellow_is_mine <= cfg.yellow_is_mine;
      end
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            hdr_seen <= hdr_hit;
            if (hdr_hit) begin
              for (int i = 0; i < FRAME_BYTES; i++) begin
                frame[i] <= rotated[i];
              end
            end
            goal_sel <= 1'b0;
            state    <= S_SETUP;
          end
        end

        S_SETUP: begin
          // X is mirrored: 255 - xb - 128 is the bit inverse less 128.
          dx       <= $signed({1'b0, ~xb} - 9'd128);
          dy       <= $signed(9'd128 - {1'b0, yb});
          g_found  <= (xb != MISSING_BYTE) && (yb != MISSING_BYTE);
          g_center <= (xb == 8'd127) && (yb == 8'd128);
          state    <= S_SQ_X;
        end

        S_SQ_X: begin
          sumsq <= mul_prod[15:0];
          state <= S_SQ_Y;
        end

        S_SQ_Y: begin
          nsh  <= {sumsq + mul_prod[15:0], 8'd0};
          rem  <= '0;
          root <= '0;
          // Fold the vector into the right half plane before rotating.
          if (dy < 0) begin
            u      <= (-dy_ext) <<< VEC_SHIFT;
            v      <= (-dx_ext) <<< VEC_SHIFT;
            g_back <= 1'b1;
          end else begin
            u      <= dy_ext <<< VEC_SHIFT;
            v      <= dx_ext <<< VEC_SHIFT;
            g_back <= 1'b0;
          end
          z     <= '0;
          cnt   <= '0;
          state <= S_ITER;
        end

        S_ITER: begin
          if (v > 0) begin
            u <= u + sv;
            v <= v - su;
            z <= z + atan_ext;
          end else begin
            u <= u - sv;
            v <= v + su;
            z <= z - atan_ext;
          end
          if (cnt < 4'(SQRT_STEPS)) begin
            nsh <= {nsh[21:0], 2'b00};
            if (sq_fit) begin
              rem  <= 14'(sq_rem_in - sq_trial);
              root <= {root[10:0], 1'b1};
            end else begin
              rem  <= sq_rem_in[13:0];
              root <= {root[10:0], 1'b0};
            end
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'(CORDIC_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!goal_sel) begin
            own_found <= g_found;
            own_angle <= angle_res;
            own_dist  <= dist_res;
            goal_sel  <= 1'b1;
            state     <= S_SETUP;
          end else begin
            opp_found <= g_found;
            opp_angle <= angle_res;
            opp_dist  <= dist_res;
            state     <= S_PUBLISH;
          end
        end

        S_PUBLISH: begin
          if (load_out) begin
            o_header_found <= hdr_seen;
            o_own_found    <= own_found;
            o_own_angle    <= own_angle;
            o_own_dist     <= own_dist;
            o_opp_found    <= opp_found;
            o_opp_angle    <= opp_angle;
            o_opp_dist     <= opp_dist;
            o_rwall_found  <= rwall_found;
            o_rwall        <= rwall_val;
            o_lwall_found  <= lwall_found;
            o_lwall        <= lwall_val;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  assign out_ch.valid             = o_valid;
  assign out_ch.header_found      = o_header_found;
  assign out_ch.own_goal_found    = o_own_found;
  assign out_ch.own_goal_angle    = o_own_angle;
  assign out_ch.own_goal_distance = o_own_dist;
  assign out_ch.opp_goal_found    = o_opp_found;
  assign out_ch.opp_goal_angle    = o_opp_angle;
  assign out_ch.opp_goal_distance = o_opp_dist;
  assign out_ch.right_wall_found  = o_rwall_found;
  assign out_ch.right_wall_offset = o_rwall;
  assign out_ch.left_wall_found   = o_lwall_found;
  assign out_ch.left_wall_offset  = o_lwall;

  // An accepted block always occupies the sequencer for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while the sequencer stayed idle");

  // Bearings delivered on the output are always inside one full turn.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.own_goal_angle < 12'd3600) &&
                     (out_ch.opp_goal_angle < 12'd3600))
    else $error("goal bearing outside 0..3599");

  // An own goal that is not seen carries zero angle and distance.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.own_goal_found |->
      (out_ch.own_goal_angle == '0) && (out_ch.own_goal_distance == '0))
    else $error("missing own goal with nonzero polar fields");

  // The CORDIC loop always ends in S_FINISH after its last rotation.
  assert property (@(posedge clk) disable iff (rst)
    state == S_ITER && cnt == 4'(CORDIC_STEPS - 1) |=> state == S_FINISH)
    else $error("CORDIC loop did not end after the last rotation");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for goal_frame_polar_decoder: raw camera blocks in,
// goal bearings, distances and wall offsets out, checked against a predictor.
// Depends on gfpd_pkg and the gfpd_in_if, gfpd_out_if and gfpd_cfg_if interfaces.
module tb;
  import gfpd_pkg::*;

  // One raw block as it arrives; element 0 is raw_byte_0.
  typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] raw_block_t;

  // Everything the decoder reports for one block.
  typedef struct {
    logic               header_found;
    logic               own_found;
    logic [ANGLE_W-1:0] own_angle;
    logic [DIST_W-1:0]  own_dist;
    logic               opp_found;
    logic [ANGLE_W-1:0] opp_angle;
    logic [DIST_W-1:0]  opp_dist;
    logic               rwall_found;
    logic [RWALL_W-1:0] rwall_ofs;
    logic               lwall_found;
    logic [LWALL_W-1:0] lwall_ofs;
  } goal_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gfpd_in_if  in_ch ();
  gfpd_out_if out_ch ();
  gfpd_cfg_if cfg ();

  goal_frame_polar_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  always #10 clk = ~clk;

  // Blocks waiting to be offered on the input channel, and the reports the
  // predictor expects, oldest first.
  raw_block_t   block_q[$];
  goal_report_t report_q[$];

  // Predictor state: the last aligned frame and the goal polarity bit.
  raw_block_t frame_copy = '0;
  logic       own_is_first = 1'b0;

  // Idle percentages of the input sender and the result receiver.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatches = 0;

  // atan(2^-i) in tenths of a degree, scaled by 2^16.
  longint atan_q16 [16] = '{
    29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
    146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146
  };

  // Clockwise bearing of (dx, dy) in tenths of a degree. The vector is
  // folded into the front half-plane first, then rotated onto the forward
  // axis by a 16-step CORDIC on vectors scaled by 2^20 with floor shifts.
  function automatic logic [ANGLE_W-1:0] cordic_bearing(input longint dx, input longint dy);
    longint u, v, z, su, sv, base;
    if (dx == 0 && dy == 0)
      return CENTER_ANGLE;
    u = dy;
    v = dx;
    z = 0;
    base = 0;
    if (u < 0) begin
      u = -u;
      v = -v;
      base = 1800;
    end
    u = u * 1048576;
    v = v * 1048576;
    for (int i = 0; i < 16; i++) begin
      su = u >>> i;
      sv = v >>> i;
      if (v > 0) begin
        u = u + sv;
        v = v - su;
        z = z + atan_q16[i];
      end else begin
        u = u - sv;
        v = v + su;
        z = z - atan_q16[i];
      end
    end
    // Add a full turn so the accumulator is positive, round half up, wrap.
    z = z + (base + 3600) * 65536;
    z = (z + 32768) >>> 16;
    return ANGLE_W'(z % 3600);
  endfunction

  // Distance in sixteenths of a pixel, rounded to nearest with exact integers.
  function automatic logic [DIST_W-1:0] rounded_distance(input longint dx, input longint dy);
    longint n, r;
    n = (dx * dx + dy * dy) * 256;
    r = 0;
    while ((r + 1) * (r + 1) <= n)
      r++;
    if (n > r * r + r)
      r++;
    return DIST_W'(r);
  endfunction

  // Polar form of one goal. X is mirrored; a 255 in either byte means the
  // goal was not seen, and then the angle and distance read zero.
  function automatic void goal_polar(input byte_t xb, input byte_t yb, output logic found,
                                     output logic [ANGLE_W-1:0] ang,
                                     output logic [DIST_W-1:0] distance);
    longint dx, dy;
    if (xb == MISSING_BYTE || yb == MISSING_BYTE) begin
      found = 1'b0;
      ang = '0;
      distance = '0;
    end else begin
      dx = 127 - longint'(xb);
      dy = 128 - longint'(yb);
      found = 1'b1;
      ang = cordic_bearing(dx, dy);
      distance = rounded_distance(dx, dy);
    end
  endfunction

  // Aligns one raw block on its last header byte (if it has one), updates
  // the stored frame and returns the report the decoder should give.
  function automatic goal_report_t decode_block(input raw_block_t raw);
    goal_report_t rep;
    int hdr;
    hdr = -1;
    for (int i = 0; i < FRAME_BYTES; i++)
      if (raw[i] == HEADER_BYTE)
        hdr = i;
    if (hdr >= 0)
      for (int i = 0; i < FRAME_BYTES; i++)
        frame_copy[i] = raw[(hdr + i) % FRAME_BYTES];
    rep.header_found = (hdr >= 0);
    if (own_is_first) begin
      goal_polar(frame_copy[1], frame_copy[2], rep.own_found, rep.own_angle, rep.own_dist);
      goal_polar(frame_copy[3], frame_copy[4], rep.opp_found, rep.opp_angle, rep.opp_dist);
    end else begin
      goal_polar(frame_copy[3], frame_copy[4], rep.own_found, rep.own_angle, rep.own_dist);
      goal_polar(frame_copy[1], frame_copy[2], rep.opp_found, rep.opp_angle, rep.opp_dist);
    end
    rep.rwall_found = (frame_copy[5] != MISSING_BYTE);
    rep.rwall_ofs = rep.rwall_found ? (9'd128 - {1'b0, frame_copy[5]}) : '0;
    rep.lwall_found = (frame_copy[6] != MISSING_BYTE);
    rep.lwall_ofs = rep.lwall_found ? (frame_copy[6] - 8'd128) : '0;
    return rep;
  endfunction

  function automatic raw_block_t make_block(input byte_t b0, input byte_t b1, input byte_t b2,
                                            input byte_t b3, input byte_t b4, input byte_t b5,
                                            input byte_t b6);
    return {b6, b5, b4, b3, b2, b1, b0};
  endfunction

  // A coordinate or wall byte: weighted toward "missing", the image edges
  // and the center line, otherwise any value except the header byte.
  function automatic byte_t field_byte();
    byte_t b;
    case ($urandom_range(11))
      0: b = MISSING_BYTE;
      1: b = 8'd0;
      2: b = 8'd254;
      3: b = 8'd127;
      4: b = 8'd128;
      default: begin
        do b = byte_t'($urandom_range(255)); while (b == HEADER_BYTE);
      end
    endcase
    return b;
  endfunction

  // Most random blocks are well-formed frames with one header, rotated by a
  // random amount as an unaligned link would deliver them. The rest are
  // blocks with no header (stored frame reused) and pure noise, which may
  // carry several header bytes.
  function automatic raw_block_t random_block();
    raw_block_t raw, frame;
    int unsigned pick, rot;
    pick = $urandom_range(99);
    if (pick < 8) begin
      for (int i = 0; i < FRAME_BYTES; i++)
        raw[i] = byte_t'($urandom_range(255));
    end else if (pick < 16) begin
      for (int i = 0; i < FRAME_BYTES; i++)
        raw[i] = field_byte();
    end else begin
      frame[0] = HEADER_BYTE;
      for (int i = 1; i < FRAME_BYTES; i++)
        frame[i] = field_byte();
      rot = $urandom_range(FRAME_BYTES - 1);
      for (int i = 0; i < FRAME_BYTES; i++)
        raw[(rot + i) % FRAME_BYTES] = frame[i];
    end
    return raw;
  endfunction

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Waits, sampling between edges, until the input side is empty and every
  // expected report has come back.
  task automatic wait_drained();
    do @(negedge clk); while (block_q.size() != 0 || in_ch.valid || report_q.size() != 0);
  endtask

  // Writes the polarity register. It is only called once the block is idle.
  task automatic write_polarity(input logic mine);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.yellow_is_mine <= mine;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Input driver. A new word is only chosen when the current one has been
  // taken or none is on offer, so valid never drops under a pending word.
  always @(posedge clk) begin : drive_blocks
    raw_block_t blk;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (block_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        blk = block_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.raw_byte_0 <= blk[0];
        in_ch.raw_byte_1 <= blk[1];
        in_ch.raw_byte_2 <= blk[2];
        in_ch.raw_byte_3 <= blk[3];
        in_ch.raw_byte_4 <= blk[4];
        in_ch.raw_byte_5 <= blk[5];
        in_ch.raw_byte_6 <= blk[6];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready is thrown at random, independent of valid.
  always @(posedge clk) begin
    if (rst)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Monitor. Results are checked before new blocks are predicted so the
  // queue order never depends on process scheduling within an edge.
  always @(posedge clk) begin : watch_channels
    goal_report_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, expected none, actual header_found=%0d",
                   $time, out_ch.header_found);
        end else begin
          want = report_q.pop_front();
          check_field("header_found", want.header_found, out_ch.header_found);
          check_field("own_goal_found", want.own_found, out_ch.own_goal_found);
          check_field("own_goal_angle", want.own_angle, out_ch.own_goal_angle);
          check_field("own_goal_distance", want.own_dist, out_ch.own_goal_distance);
          check_field("opp_goal_found", want.opp_found, out_ch.opp_goal_found);
          check_field("opp_goal_angle", want.opp_angle, out_ch.opp_goal_angle);
          check_field("opp_goal_distance", want.opp_dist, out_ch.opp_goal_distance);
          check_field("right_wall_found", want.rwall_found, out_ch.right_wall_found);
          check_field("right_wall_offset", $signed(want.rwall_ofs),
                      $signed(out_ch.right_wall_offset));
          check_field("left_wall_found", want.lwall_found, out_ch.left_wall_found);
          check_field("left_wall_offset", $signed(want.lwall_ofs),
                      $signed(out_ch.left_wall_offset));
        end
      end
      if (cfg.valid && cfg.ready)
        own_is_first = cfg.yellow_is_mine;
      if (in_ch.valid && in_ch.ready)
        report_q.push_back(decode_block({in_ch.raw_byte_6, in_ch.raw_byte_5, in_ch.raw_byte_4,
                                         in_ch.raw_byte_3, in_ch.raw_byte_2, in_ch.raw_byte_1,
                                         in_ch.raw_byte_0}));
    end
  end

  // Stimulus and end of test.
  initial begin : stimulus
    in_ch.valid = 1'b0;
    in_ch.raw_byte_0 = '0;
    in_ch.raw_byte_1 = '0;
    in_ch.raw_byte_2 = '0;
    in_ch.raw_byte_3 = '0;
    in_ch.raw_byte_4 = '0;
    in_ch.raw_byte_5 = '0;
    in_ch.raw_byte_6 = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.yellow_is_mine = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first with the sender idling 38% and the receiver 45%.
    src_idle_pct = 38;
    snk_idle_pct = 45;
    write_polarity(1'b0);
    // No header straight after reset: the all-zero stored frame is decoded.
    block_q.push_back(make_block(0, 0, 0, 0, 0, 0, 0));
    // One goal at the image centre, and one straight ahead.
    block_q.push_back(make_block(2, 127, 128, 127, 0, 128, 128));
    // Goals on the side axes; walls at the far edges of their range.
    block_q.push_back(make_block(2, 0, 128, 254, 128, 0, 0));
    // One goal missing through its X byte; directly behind; walls at 254.
    block_q.push_back(make_block(2, 127, 254, 255, 10, 254, 254));
    // One goal missing through its Y byte; both walls missing.
    block_q.push_back(make_block(2, 10, 255, 0, 0, 255, 255));
    // Header in the middle of the block, so the block must be rotated.
    block_q.push_back(make_block(40, 50, 2, 60, 70, 80, 90));
    // Two header bytes: the later one wins.
    block_q.push_back(make_block(2, 1, 3, 2, 5, 6, 7));
    block_q.push_back(make_block(2, 2, 2, 2, 2, 2, 2));
    // No header at all: the stored frame is reused.
    block_q.push_back(make_block(255, 255, 255, 255, 255, 255, 255));
    // Header in the last position.
    block_q.push_back(make_block(11, 22, 33, 44, 55, 66, 2));
    block_q.push_back(make_block(254, 254, 254, 254, 254, 254, 2));
    // Image corners, then a frame whose header sits in the middle.
    block_q.push_back(make_block(2, 0, 0, 0, 254, 127, 129));
    block_q.push_back(make_block(8'h80, 8'h7f, 8'h01, 8'hfe, 2, 8'h55, 8'haa));
    // Bytes next to the header value do not count as a header.
    block_q.push_back(make_block(3, 1, 0, 255, 4, 5, 6));
    wait_drained();

    // Same frames again with the goals swapped by the polarity bit.
    write_polarity(1'b1);
    block_q.push_back(make_block(2, 127, 128, 127, 0, 128, 128));
    block_q.push_back(make_block(2, 0, 128, 254, 128, 0, 0));
    block_q.push_back(make_block(2, 127, 254, 255, 10, 254, 254));
    block_q.push_back(make_block(2, 10, 255, 0, 0, 255, 255));
    block_q.push_back(make_block(2, 0, 0, 0, 254, 127, 129));
    block_q.push_back(make_block(0, 1, 3, 4, 5, 6, 7));

    // Random part: six rounds of 200 blocks. Each pair of rounds shares an
    // idling profile and visits both polarities. Halfway through each round
    // the sender holds off until every result is back.
    for (int rnd = 0; rnd < 6; rnd++) begin
      wait_drained();
      src_idle_pct = (rnd < 2) ? 38 : (rnd < 4) ? 45 : 0;
      snk_idle_pct = (rnd < 2) ? 45 : (rnd < 4) ? 38 : 0;
      write_polarity(rnd[0]);
      for (int n = 0; n < 200; n++) begin
        if (n == 100)
          wait_drained();
        block_q.push_back(random_block());
      end
    end

    // Let everything come back, then give the block time to show any
    // stray extra word.
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0)
      $display("goal_frame_polar_decoder regression: pass");
    else
      $display("goal_frame_polar_decoder regression: fail");
    $finish;
  end

  // Watchdog: well past the slowest legal run of about 1250 blocks.
  initial begin
    #16000000;
    $display("goal_frame_polar_decoder regression: fail");
    $finish;
  end

endmodule
